// ===== rtl/ocpi_pkg.sv =====
// Shared types and constants for the octree path insert block.
package ocpi_pkg;

    localparam int NODES       = 4096;
    localparam int DEPTH_MAX   = 20;
    localparam int MODEL_SLOTS = 4;
    localparam int COORD_BITS  = 20;

    localparam int COORD_W  = COORD_BITS;
    localparam int DEPTH_W  = 5;
    localparam int SEL_W    = 2;
    localparam int NODE_W   = $clog2(NODES);
    localparam int CNT_W    = NODE_W + 1;
    localparam int OCT_W    = 3;
    localparam int STATUS_W = 2;
    localparam int ADDED_W  = 5;
    localparam int MCOUNT_W = 3;
    localparam int ROOT_W   = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam int IN_FIELD_W  = 3 * COORD_W + DEPTH_W + SEL_W;
    localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_FIELD_W = STATUS_W + NODE_W + OCT_W + ADDED_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_MODEL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_DEPTH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LOADED_MODELS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_ZERO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_ONE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TWO      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_THREE    = 3'd4;

    typedef struct packed {
        logic load;   // latch an accepted request
        logic rd;     // issue node store reads for the current level
        logic eval;   // resolve the current level
        logic push;   // move the result into the output register
    } t_cmd;

    typedef struct packed {
        logic early;     // incoming request is rejected without descent
        logic stop;      // current level ends the descent
        logic out_free;  // output register can take a result
        logic clearing;  // valid-bit store is being zeroed after reset
    } t_stat;

endpackage

// ===== rtl/ocpi_ctrl.sv =====
// Sequencer for the octree insert: accept, per-level read/resolve, result hand-off.
module ocpi_ctrl
    import ocpi_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_axis_tvalid,
    output logic  o_s_axis_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_READ   = 4'b0010,
        S_EVAL   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    // hold off requests until the valid-bit store is cleared
    assign o_s_axis_tready = (r_state == S_IDLE) && !i_stat.clearing;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.early ? S_FINISH : S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_stat.stop ? S_FINISH : S_READ;
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/ocpi_dp.sv =====
// Datapath for the octree insert: coordinates, midpoints, node stores and result register.
module ocpi_dp
    import ocpi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam logic [COORD_W-1:0] MID_HALF = COORD_W'(1) << (COORD_W - 1);
    localparam logic [DEPTH_W-1:0] DEPTH_CAP = DEPTH_W'(DEPTH_MAX);
    localparam logic [CNT_W-1:0]   NODE_LIMIT = CNT_W'(NODES);

    // node stores
    logic [7:0]        valid_mem [NODES];
    logic [NODE_W-1:0] child_mem [NODES*8];

    // configuration
    logic [MCOUNT_W-1:0] r_loaded_models;
    logic [ROOT_W-1:0]   r_roots [MODEL_SLOTS];

    // request and walk state
    logic [COORD_W-1:0] r_px, r_py, r_pz;
    logic [COORD_W-1:0] r_mx, r_my, r_mz;
    logic [DEPTH_W-1:0] r_depth;
    logic [SEL_W-1:0]   r_sel;
    logic [DEPTH_W-1:0] r_lvl;
    logic [NODE_W-1:0]  r_node;
    logic [OCT_W-1:0]   r_oct;
    logic               r_fresh;
    logic [ADDED_W-1:0] r_added;
    logic [CNT_W-1:0]   r_node_cnt;
    logic [7:0]         r_root_vb;
    logic [7:0]         r_vb_rd;
    logic [NODE_W-1:0]  r_child_rd;
    logic               r_clearing;
    logic [NODE_W-1:0]  r_clr_addr;

    // result and output register
    logic [STATUS_W-1:0] r_res_status;
    logic [NODE_W-1:0]   r_res_node;
    logic [OCT_W-1:0]    r_res_slot;
    logic [ADDED_W-1:0]  r_res_added;
    logic                r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // incoming fields
    logic [COORD_W-1:0] in_x, in_y, in_z;
    logic [DEPTH_W-1:0] in_depth;
    logic [SEL_W-1:0]   in_sel;
    logic               in_bad_model;
    logic               in_zero_depth;

    // per-level logic
    logic [OCT_W-1:0]   oct;
    logic [7:0]         vb;
    logic [7:0]         oct_bit;
    logic               last_lvl;
    logic               has_child;
    logic               next_out;
    logic               store_full;
    logic [COORD_W-1:0] step;
    logic [ROOT_W-1:0]  root_ptr;

    logic               vm_we;
    logic [NODE_W-1:0]  vm_addr;
    logic [7:0]         vm_wdata;
    logic               cm_we;
    logic [NODE_W-1:0]  cm_wdata;

    assign in_x     = i_s_axis_tdata[COORD_W-1:0];
    assign in_y     = i_s_axis_tdata[2*COORD_W-1:COORD_W];
    assign in_z     = i_s_axis_tdata[3*COORD_W-1:2*COORD_W];
    assign in_depth = i_s_axis_tdata[3*COORD_W+DEPTH_W-1:3*COORD_W];
    assign in_sel   = i_s_axis_tdata[IN_FIELD_W-1:3*COORD_W+DEPTH_W];

    assign in_bad_model  = ({1'b0, in_sel} >= r_loaded_models)
                        || ({1'b0, in_sel} >= MCOUNT_W'(MODEL_SLOTS));
    assign in_zero_depth = (in_depth == '0);

    assign oct = {r_pz > r_mz, r_py > r_my, r_px > r_mx};

    assign vb         = (r_node == '0) ? r_root_vb : (r_fresh ? 8'd0 : r_vb_rd);
    assign oct_bit    = 8'd1 << r_oct;
    assign last_lvl   = (r_lvl == r_depth - DEPTH_W'(1));
    assign has_child  = |(vb & oct_bit);
    assign next_out   = ({1'b0, r_child_rd} >= NODE_LIMIT);
    assign store_full = (r_node_cnt >= NODE_LIMIT);
    assign step       = MID_HALF >> (r_lvl + DEPTH_W'(1));
    assign root_ptr   = r_roots[r_sel];

    assign o_stat.early    = in_bad_model || in_zero_depth;
    assign o_stat.stop     = last_lvl || (has_child ? next_out : store_full);
    assign o_stat.out_free = !r_out_valid || i_m_axis_tready;
    assign o_stat.clearing = r_clearing;

    // store writes for the clearing pass and the resolve step; one write per store per cycle
    always_comb begin
        vm_we    = 1'b0;
        vm_addr  = r_node;
        vm_wdata = vb | oct_bit;
        cm_we    = 1'b0;
        cm_wdata = r_node_cnt[NODE_W-1:0];
        if (r_clearing) begin
            vm_we    = 1'b1;
            vm_addr  = r_clr_addr;
            vm_wdata = 8'd0;
        end else if (i_cmd.eval) begin
            if (last_lvl) begin
                cm_we    = 1'b1;
                cm_wdata = NODE_W'(root_ptr);
                vm_we    = (r_node != '0);
            end else if (!has_child) begin
                if (store_full) begin
                    // clear a freshly allocated node left behind by the stop
                    vm_we    = r_fresh;
                    vm_wdata = 8'd0;
                end else begin
                    cm_we = 1'b1;
                    vm_we = (r_node != '0);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (vm_we) begin
            valid_mem[vm_addr] <= vm_wdata;
        end
        if (cm_we) begin
            child_mem[{r_node, r_oct}] <= cm_wdata;
        end
        if (i_cmd.rd) begin
            r_vb_rd    <= valid_mem[r_node];
            r_child_rd <= child_mem[{r_node, oct}];
        end
    end

    // zero the valid-bit store once after reset, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + NODE_W'(1);
            if (r_clr_addr == NODE_W'(NODES - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded_models <= '0;
            for (int i = 0; i < MODEL_SLOTS; i++) begin
                r_roots[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOADED_MODELS: r_loaded_models <= i_cfg_wdata[MCOUNT_W-1:0];
                CFG_ROOT_ZERO:   r_roots[0] <= i_cfg_wdata[ROOT_W-1:0];
                CFG_ROOT_ONE:    if (MODEL_SLOTS > 1) r_roots[1 % MODEL_SLOTS] <= i_cfg_wdata;
                CFG_ROOT_TWO:    if (MODEL_SLOTS > 2) r_roots[2 % MODEL_SLOTS] <= i_cfg_wdata;
                CFG_ROOT_THREE:  if (MODEL_SLOTS > 3) r_roots[3 % MODEL_SLOTS] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // walk state and node count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_cnt <= CNT_W'(1);
            r_root_vb  <= '0;
        end else if (i_cmd.eval && (r_node == '0)) begin
            if (last_lvl || (!has_child && !store_full)) begin
                r_root_vb <= vb | oct_bit;
            end
        end
        if (i_rst_n && i_cmd.eval && !last_lvl && !has_child && !store_full) begin
            r_node_cnt <= r_node_cnt + CNT_W'(1);
        end

        if (i_cmd.load) begin
            r_px    <= in_x;
            r_py    <= in_y;
            r_pz    <= in_z;
            r_mx    <= MID_HALF;
            r_my    <= MID_HALF;
            r_mz    <= MID_HALF;
            r_depth <= (in_depth > DEPTH_CAP) ? DEPTH_CAP : in_depth;
            r_sel   <= in_sel;
            r_lvl   <= '0;
            r_node  <= '0;
            r_fresh <= 1'b0;
            r_added <= '0;
            r_res_node  <= '0;
            r_res_slot  <= '0;
            r_res_added <= '0;
            r_res_status <= in_bad_model ? ST_BAD_MODEL
                          : (in_zero_depth ? ST_ZERO_DEPTH : ST_OK);
        end
        if (i_cmd.rd) begin
            r_oct <= oct;
        end
        if (i_cmd.eval) begin
            if (last_lvl) begin
                r_res_status <= ST_OK;
                r_res_node   <= r_node;
                r_res_slot   <= r_oct;
                r_res_added  <= r_added;
            end else if (has_child ? next_out : store_full) begin
                r_res_status <= ST_FULL;
                r_res_node   <= r_node;
                r_res_slot   <= r_oct;
                r_res_added  <= r_added;
            end else begin
                r_mx  <= r_oct[0] ? r_mx + step : r_mx - step;
                r_my  <= r_oct[1] ? r_my + step : r_my - step;
                r_mz  <= r_oct[2] ? r_mz + step : r_mz - step;
                r_lvl <= r_lvl + DEPTH_W'(1);
                if (has_child) begin
                    r_node  <= r_child_rd;
                    r_fresh <= 1'b0;
                end else begin
                    r_node  <= r_node_cnt[NODE_W-1:0];
                    r_fresh <= 1'b1;
                    r_added <= r_added + ADDED_W'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.push) begin
            r_out_data <= OUT_DATA_W'({r_res_added, r_res_slot, r_res_node, r_res_status});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ===== rtl/octree_path_insert_place.sv =====
// Top level of the octree path insert: links a model root into the node store.
//
// Input stream (s_axis): one request per point; tdata carries pos_x, pos_y,
// pos_z, depth and model_sel. Output stream (m_axis): one result per request
// with status, parent_node, slot and nodes_added.
// Configuration: i_cfg_we/i_cfg_idx/i_cfg_wdata write the loaded-model count
// (0) and the four model root pointers (1..4); write only while no request is in flight.
// Sequence: a request passes an accept state, then per octree level a node store
// read and a resolve with any allocation write, then a finish state that loads
// the output register once it is free. Rejected requests (bad model, zero depth)
// skip the descent and go from accept straight to the finish state. One request is
// worked at a time: a new one is taken only after the last result is pushed.
// The output register holds a result while the receiver stalls; a new request
// is taken meanwhile, and its result waits until the register is free.
// After reset the valid-bit store is zeroed one entry per cycle with tready held
// low; the root node then stands alone with no children.
// The child pointer store needs no clearing pass, since only written entries are read.
module octree_path_insert_place
    import ocpi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // pos_x[19:0], pos_y[39:20], pos_z[59:40], depth[64:60], model_sel[66:65]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // status[1:0], parent_node[13:2], slot[16:14], nodes_added[21:17]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cmd  cmd;
    t_stat stat;

    ocpi_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (stat),
        .o_cmd           (cmd)
    );

    ocpi_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

endmodule

// ===== tb/octree_path_insert_place_chk.sv =====
`timescale 1ns / 1ps
// Stream monitor for the octree path insert: mirrors the node store and scores each result.
module octree_path_insert_place_chk
    import ocpi_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    // pos_x, pos_y, pos_z, depth, model_sel from the lowest bit up
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    // status, parent_node, slot, nodes_added from the lowest bit up
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_mismatches,
    output int                    o_waiting,
    output int                    o_node_count
);

    typedef struct packed {
        logic [ADDED_W-1:0]  added;
        logic [OCT_W-1:0]    slot;
        logic [NODE_W-1:0]   parent;
        logic [STATUS_W-1:0] status;
    } t_placement;

    localparam int SCALE_W = COORD_BITS + DEPTH_MAX;

    logic [7:0]          slot_used [NODES];
    logic [NODE_W-1:0]   link_to [NODES*8];
    int unsigned         alloc_count;
    logic [MCOUNT_W-1:0] models_live;
    logic [ROOT_W-1:0]   model_root [MODEL_SLOTS];
    t_placement          placements_due [$];

    // Walk the tree for one request, growing it the way the block does.
    function automatic t_placement place_in_tree(input logic [IN_DATA_W-1:0] req);
        logic [SCALE_W-1:0] px, py, pz, mx, my, mz, half;
        logic [DEPTH_W-1:0] d;
        logic [SEL_W-1:0]   sel;
        logic [OCT_W-1:0]   oct;
        int unsigned        node, added, e, fresh;
        t_placement         r;
        r     = '0;
        px    = {req[COORD_W-1:0], {DEPTH_MAX{1'b0}}};
        py    = {req[2*COORD_W-1:COORD_W], {DEPTH_MAX{1'b0}}};
        pz    = {req[3*COORD_W-1:2*COORD_W], {DEPTH_MAX{1'b0}}};
        d     = req[3*COORD_W +: DEPTH_W];
        sel   = req[3*COORD_W+DEPTH_W +: SEL_W];
        node  = 0;
        added = 0;
        if (sel >= models_live || int'(sel) >= MODEL_SLOTS) begin
            r.status = ST_BAD_MODEL;
            return r;
        end
        if (d == 0) begin
            r.status = ST_ZERO_DEPTH;
            return r;
        end
        if (d > DEPTH_MAX) d = DEPTH_W'(DEPTH_MAX);
        mx = SCALE_W'(1) << (SCALE_W - 1);
        my = mx;
        mz = mx;
        for (int lvl = 0; lvl < int'(d); lvl++) begin
            oct = {pz > mz, py > my, px > mx};
            e   = node * 8 + oct;
            if (lvl == int'(d) - 1) begin
                link_to[e]          = model_root[sel];
                slot_used[node][oct] = 1'b1;
                r.status = ST_OK;
                r.parent = NODE_W'(node);
                r.slot   = oct;
                r.added  = ADDED_W'(added);
                return r;
            end
            half = SCALE_W'(1) << (SCALE_W - 2 - lvl);
            mx = oct[0] ? mx + half : mx - half;
            my = oct[1] ? my + half : my - half;
            mz = oct[2] ? mz + half : mz - half;
            if (slot_used[node][oct]) begin
                node = link_to[e];
            end else begin
                if (alloc_count >= NODES) begin
                    r.status = ST_FULL;
                    r.parent = NODE_W'(node);
                    r.slot   = oct;
                    r.added  = ADDED_W'(added);
                    return r;
                end
                fresh            = alloc_count;
                alloc_count++;
                slot_used[fresh] = '0;
                link_to[e]       = NODE_W'(fresh);
                slot_used[node][oct] = 1'b1;
                added++;
                node = fresh;
            end
        end
        r.parent = NODE_W'(node);
        r.added  = ADDED_W'(added);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_placement got, want;
        if (!i_rst_n) begin
            foreach (slot_used[i]) slot_used[i] = '0;
            alloc_count  = 1;
            models_live  = '0;
            foreach (model_root[i]) model_root[i] = '0;
            placements_due.delete();
            o_mismatches <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOADED_MODELS: models_live = i_cfg_wdata[MCOUNT_W-1:0];
                    CFG_ROOT_ZERO:   model_root[0] = i_cfg_wdata[ROOT_W-1:0];
                    CFG_ROOT_ONE:    model_root[1] = i_cfg_wdata[ROOT_W-1:0];
                    CFG_ROOT_TWO:    model_root[2] = i_cfg_wdata[ROOT_W-1:0];
                    CFG_ROOT_THREE:  model_root[3] = i_cfg_wdata[ROOT_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                placements_due.push_back(place_in_tree(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[OUT_FIELD_W-1:0];
                if (placements_due.size() == 0) begin
                    $display("%0t: unrequested result status %0d parent %0d slot %0d added %0d",
                             $time, got.status, got.parent, got.slot, got.added);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = placements_due.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected status %0d parent %0d slot %0d added %0d",
                                 $time, want.status, want.parent, want.slot, want.added);
                        $display("%0t:   actual status %0d parent %0d slot %0d added %0d",
                                 $time, got.status, got.parent, got.slot, got.added);
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
        end
        o_waiting    <= placements_due.size();
        o_node_count <= alloc_count;
    end

endmodule

// ===== tb/octree_path_insert_place_tb.sv =====
`timescale 1ns / 1ps
// Top of the octree path insert testbench: clock, reset, request stimulus and verdict.
module octree_path_insert_place_tb
    import ocpi_pkg::*;
();

    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_OFF    = 400;
    localparam int PHASE_ITEMS = 85;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_ROOT_THREE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int mismatches, waiting, node_count;
    int quiet = 0;
    int results_seen = 0;
    bit calm = 1'b0;

    logic [3*COORD_W-1:0] recent [32];
    int hist_wr = 0;
    int hist_fill = 0;

    octree_path_insert_place DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata)
    );

    octree_path_insert_place_chk u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_wdata  (cfg_wdata),
        .o_mismatches (mismatches),
        .o_waiting    (waiting),
        .o_node_count (node_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (m_tvalid && m_tready) results_seen <= results_seen + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("octree_path_insert_place_tb failed");
            $finish;
        end
    end

    function automatic int idle_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_request(
        input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
        input logic [COORD_W-1:0] z, input logic [DEPTH_W-1:0] d,
        input logic [SEL_W-1:0] sel);
        return {{(IN_DATA_W-IN_FIELD_W){1'b0}}, sel, d, z, y, x};
    endfunction

    function automatic logic [COORD_W-1:0] corner_coord();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return COORD_W'(1) << (COORD_W - 1);
            3: return (COORD_W'(1) << (COORD_W - 1)) + 1'b1;
            4: return (COORD_W'(1) << (COORD_W - 1)) - 1'b1;
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // Often revisit or brush past earlier points so descents reuse the tree.
    function automatic logic [IN_DATA_W-1:0] make_request(input int deep_pct);
        logic [3*COORD_W-1:0] pt;
        logic [COORD_W-1:0]   mask;
        logic [DEPTH_W-1:0]   d;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25 && hist_fill > 0) begin
            pt = recent[$urandom_range(0, hist_fill - 1)];
        end else if (pick < 40 && hist_fill > 0) begin
            pt   = recent[$urandom_range(0, hist_fill - 1)];
            mask = (COORD_W'(1) << $urandom_range(1, 8)) - 1'b1;
            pt   = pt ^ {COORD_W'($urandom) & mask, COORD_W'($urandom) & mask,
                         COORD_W'($urandom) & mask};
        end else if (pick < 90) begin
            pt = {COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom)};
        end else begin
            pt = {corner_coord(), corner_coord(), corner_coord()};
        end
        if ($urandom_range(0, 99) < deep_pct) d = DEPTH_W'($urandom_range(12, 31));
        else if ($urandom_range(0, 99) < 4) d = '0;
        else d = DEPTH_W'($urandom_range(1, 8));
        recent[hist_wr] = pt;
        hist_wr = (hist_wr + 1) % 32;
        if (hist_fill < 32) hist_fill++;
        return {{(IN_DATA_W-IN_FIELD_W){1'b0}}, SEL_W'($urandom_range(0, 3)), d, pt};
    endfunction

    task automatic push_request(input logic [IN_DATA_W-1:0] req);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (waiting != 0) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge clk);
    endtask

    // Roots stay below the live node count so a followed pointer lands on a built node.
    function automatic logic [ROOT_W-1:0] pick_root();
        int lim;
        lim = node_count - 1;
        case ($urandom_range(0, 3))
            0: return '0;
            1: return ROOT_W'(lim);
            default: return ROOT_W'($urandom_range(0, lim));
        endcase
    endfunction

    task automatic configure(input logic [MCOUNT_W-1:0] count);
        write_reg(CFG_LOADED_MODELS, {(CFG_DATA_W-MCOUNT_W)'($urandom), count});
        write_reg(CFG_ROOT_ZERO, pick_root());
        write_reg(CFG_ROOT_ONE, pick_root());
        write_reg(CFG_ROOT_TWO, pick_root());
        write_reg(CFG_ROOT_THREE, pick_root());
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)),
                      CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Receiver: random backpressure plus occasional long hold-offs to fill the block.
    initial begin
        int gap;
        int next_squeeze;
        next_squeeze = 150;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (results_seen >= next_squeeze) begin
                next_squeeze += 300;
                m_tready <= 1'b0;
                repeat (HOLD_OFF) @(negedge clk);
            end
            gap = idle_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    end

    initial begin
        logic [COORD_W-1:0] mid, quarter, three_q;
        logic [MCOUNT_W-1:0] phase_models [8];
        mid     = COORD_W'(1) << (COORD_W - 1);
        quarter = COORD_W'(1) << (COORD_W - 2);
        three_q = mid + quarter;
        phase_models = '{3'd2, 3'd7, 3'd1, 3'd4, 3'd3, 3'd6, 3'd4, 3'd5};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // no models loaded yet: everything is rejected, bad model before zero depth
        push_request(pack_request(20'h12345, 20'hABCDE, 20'h55555, 5'd5, 2'd0));
        push_request(pack_request('0, '0, '0, 5'd0, 2'd3));
        drain();
        configure(3'd4);

        push_request(pack_request('0, '0, '0, 5'd0, 2'd0));
        push_request(pack_request('1, '1, '1, 5'd1, 2'd1));
        push_request(pack_request('0, '0, '0, 5'd1, 2'd2));
        // exact midpoint stays in the lower half
        push_request(pack_request(mid, mid, mid, 5'd1, 2'd0));
        push_request(pack_request(mid + 1'b1, mid + 1'b1, mid + 1'b1, 5'd1, 2'd1));
        push_request(pack_request(mid + 1'b1, mid, mid + 1'b1, 5'd1, 2'd2));
        push_request(pack_request('1, '1, '1, 5'd20, 2'd3));
        push_request(pack_request('1, '1, '1, 5'd20, 2'd0));
        push_request(pack_request('0, '0, '0, 5'd20, 2'd1));
        push_request(pack_request('0, '0, '0, 5'd31, 2'd2));
        push_request(pack_request(20'h9E3B7, 20'h1C0DE, 20'hF00F1, 5'd21, 2'd3));
        push_request(pack_request(quarter, three_q, quarter - 1'b1, 5'd3, 2'd0));
        push_request(pack_request(quarter + 1'b1, three_q + 1'b1, quarter, 5'd3, 2'd1));
        // place a model shallow, then descend through its root pointer
        push_request(pack_request(20'h2AAAA, 20'h15555, 20'h6789A, 5'd2, 2'd1));
        push_request(pack_request(20'h2AAAA, 20'h15555, 20'h6789A, 5'd6, 2'd2));
        push_request(pack_request('1, '0, '1, 5'd20, 2'd2));
        push_request(pack_request('0, '1, '0, 5'd19, 2'd3));
        push_request(pack_request(20'h5A5A5, 20'hA5A5A, 20'h3C3C3, 5'd0, 2'd3));
        drain();
        configure(3'd7);
        for (int s = 0; s < MODEL_SLOTS; s++)
            push_request(pack_request(COORD_W'($urandom), COORD_W'($urandom),
                                      COORD_W'($urandom), 5'd4, SEL_W'(s)));

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            calm = (ph % 3 == 1);
            configure(phase_models[ph]);
            repeat (PHASE_ITEMS) push_request(make_request(ph < 4 ? 25 : 85));
        end

        drain();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && waiting == 0)
            $display("octree_path_insert_place_tb passed");
        else
            $display("octree_path_insert_place_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ocpi_pkg.sv
rtl/ocpi_ctrl.sv
rtl/ocpi_dp.sv
rtl/octree_path_insert_place.sv
tb/octree_path_insert_place_chk.sv
tb/octree_path_insert_place_tb.sv
